// File: design/fccsg_pkg.sv
`default_nettype none
package fccsg_pkg;

    localparam int unsigned SECTOR_BYTES        = 512;
    localparam int unsigned DIR_ENTRY_BYTES     = 32;
    localparam int unsigned MAX_CLUSTER_SECTORS = 64;

    localparam int unsigned ENTRY_SHIFT = $clog2(SECTOR_BYTES / 2);
    localparam int unsigned ROOT_SHIFT  = $clog2(SECTOR_BYTES / DIR_ENTRY_BYTES);

    localparam int unsigned CLUSTER_W  = 16;
    localparam int unsigned VOL_W      = 32;
    localparam int unsigned FD_W       = 25;
    localparam int unsigned FAT_SEC_W  = 17;
    localparam int unsigned FAT_WORD_W = ENTRY_SHIFT;
    localparam int unsigned CS_REG_W   = 7;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned SETTLE_W   = 2;

    localparam logic [CLUSTER_W-1:0] BAD_CLUSTER = 16'hFFF7;
    localparam logic [CLUSTER_W-1:0] END_FIRST   = 16'hFFF8;

    typedef enum logic [2:0] {
        REG_VOLUME,
        REG_RESERVED,
        REG_FAT_LENGTH,
        REG_FAT_COPIES,
        REG_ROOT_ENTRIES,
        REG_CLUSTER_SECTORS
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_END,
        KIND_ERROR
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_RESERVED,
        ERR_BAD,
        ERR_RANGE
    } err_t;

    typedef struct packed {
        logic [FD_W-1:0]      first_data;
        logic [VOL_W-1:0]     avail;
        logic                 short_vol;
        logic [15:0]          reserved;
    } geom_t;

    typedef struct packed {
        kind_t                kind;
        err_t                 err;
        logic [CLUSTER_W-1:0] cluster;
    } item_t;

endpackage
`default_nettype wire

// File: design/fccsg_cfg.sv
`default_nettype none
module fccsg_cfg #(
    parameter int unsigned MAX_CS = fccsg_pkg::MAX_CLUSTER_SECTORS,
    localparam int unsigned CS_W = $clog2(MAX_CS + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fccsg_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [fccsg_pkg::DATA_W-1:0]  pwdata,
    output logic      [fccsg_pkg::DATA_W-1:0]  prdata,
    output logic                               pready,
    output fccsg_pkg::geom_t                   geom,
    output logic      [CS_W-1:0]               cs_eff,
    output logic                               settling
);
    import fccsg_pkg::*;

    logic [VOL_W-1:0]    vol_reg;
    logic [15:0]         rsv_reg;
    logic [15:0]         fat_len_reg;
    logic [7:0]          fat_cnt_reg;
    logic [15:0]         root_reg;
    logic [CS_REG_W-1:0] cs_reg;

    logic [SETTLE_W-1:0] settle_reg;
    logic [SETTLE_W-1:0] settle_next;

    logic [FD_W-1:0]     fd_reg;
    logic [FD_W-1:0]     fd_next;
    logic [CS_W-1:0]     cs_eff_reg;
    logic [CS_W-1:0]     cs_eff_next;
    logic [VOL_W-1:0]    avail_reg;
    logic                short_reg;
    logic [VOL_W:0]      diff;

    logic [16:0]         root_sum;
    logic [16:0]         root_secs;
    logic [23:0]         fat_area;
    logic                wr;
    reg_idx_t            idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_reg     <= '0;
            rsv_reg     <= 16'd1;
            fat_len_reg <= '0;
            fat_cnt_reg <= 8'd2;
            root_reg    <= 16'd512;
            cs_reg      <= 7'd4;
        end
        else if (wr)
        begin
            case (idx)
                REG_VOLUME:          vol_reg     <= pwdata;
                REG_RESERVED:        rsv_reg     <= pwdata[15:0];
                REG_FAT_LENGTH:      fat_len_reg <= pwdata[15:0];
                REG_FAT_COPIES:      fat_cnt_reg <= pwdata[7:0];
                REG_ROOT_ENTRIES:    root_reg    <= pwdata[15:0];
                REG_CLUSTER_SECTORS: cs_reg      <= pwdata[CS_REG_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_VOLUME:          prdata = vol_reg;
            REG_RESERVED:        prdata = DATA_W'(rsv_reg);
            REG_FAT_LENGTH:      prdata = DATA_W'(fat_len_reg);
            REG_FAT_COPIES:      prdata = DATA_W'(fat_cnt_reg);
            REG_ROOT_ENTRIES:    prdata = DATA_W'(root_reg);
            REG_CLUSTER_SECTORS: prdata = DATA_W'(cs_reg);
            default:             prdata = '0;
        endcase
    end

    // geometry, recomputed every cycle; held valid by the settle window
    assign root_sum  = 17'(root_reg) + 17'(SECTOR_BYTES / DIR_ENTRY_BYTES - 1);
    assign root_secs = root_sum >> ROOT_SHIFT;
    assign fat_area  = 24'(fat_len_reg) * 24'(fat_cnt_reg);
    assign fd_next   = FD_W'(rsv_reg) + FD_W'(fat_area) + FD_W'(root_secs);

    always_comb
    begin
        if (cs_reg == '0)
            cs_eff_next = CS_W'(1);
        else if (32'(cs_reg) > MAX_CS)
            cs_eff_next = CS_W'(MAX_CS);
        else
            cs_eff_next = CS_W'(cs_reg);
    end

    assign diff = {1'b0, vol_reg} - (VOL_W + 1)'(fd_reg);

    always_ff @(posedge clk)
    begin
        fd_reg     <= fd_next;
        cs_eff_reg <= cs_eff_next;
        avail_reg  <= diff[VOL_W-1:0];
        short_reg  <= diff[VOL_W];
    end

    always_comb
    begin
        if (wr)
            settle_next = '1;
        else if (settle_reg != '0)
            settle_next = settle_reg - SETTLE_W'(1);
        else
            settle_next = settle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= '1;
        else
            settle_reg <= settle_next;
    end

    assign settling        = (settle_reg != '0);
    assign cs_eff          = cs_eff_reg;
    assign geom.first_data = fd_reg;
    assign geom.avail      = avail_reg;
    assign geom.short_vol  = short_reg;
    assign geom.reserved   = rsv_reg;

endmodule
`default_nettype wire

// File: design/fccsg_classify.sv
`default_nettype none
module fccsg_classify #(
    parameter int unsigned MAX_CS = fccsg_pkg::MAX_CLUSTER_SECTORS,
    localparam int unsigned CS_W = $clog2(MAX_CS + 1),
    localparam int unsigned PW = fccsg_pkg::CLUSTER_W + CS_W
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [fccsg_pkg::CLUSTER_W-1:0] cluster,
    input  wire logic                            settling,
    input  wire logic [CS_W-1:0]                 cs_eff,
    input  wire logic                            take,
    output logic                                 busy,
    output logic                                 item_valid,
    output fccsg_pkg::item_t                     item,
    output logic      [PW-1:0]                   prod
);
    import fccsg_pkg::*;

    logic                 v1_reg;
    logic                 v1_next;
    logic [CLUSTER_W-1:0] c1_reg;
    logic                 v2_reg;
    logic                 v2_next;
    item_t                item_reg;
    item_t                item_next;
    logic [PW-1:0]        prod_reg;
    logic [PW-1:0]        prod_next;
    logic [CLUSTER_W-1:0] c_off;
    logic                 accept;
    logic                 adv1;

    assign adv1   = v1_reg && (!v2_reg || take);
    assign busy   = settling || (v1_reg && !adv1);
    assign accept = start && !busy;

    assign c_off     = c1_reg - CLUSTER_W'(2);
    assign prod_next = PW'(c_off) * PW'(cs_eff);

    always_comb
    begin
        item_next.cluster = c1_reg;
        if (c1_reg < CLUSTER_W'(2))
        begin
            item_next.kind = KIND_ERROR;
            item_next.err  = ERR_RESERVED;
        end
        else if (c1_reg == BAD_CLUSTER)
        begin
            item_next.kind = KIND_ERROR;
            item_next.err  = ERR_BAD;
        end
        else if (c1_reg >= END_FIRST)
        begin
            item_next.kind = KIND_END;
            item_next.err  = ERR_NONE;
        end
        else
        begin
            item_next.kind = KIND_DATA;
            item_next.err  = ERR_NONE;
        end
    end

    always_comb
    begin
        if (accept)
            v1_next = 1'b1;
        else if (adv1)
            v1_next = 1'b0;
        else
            v1_next = v1_reg;

        if (adv1)
            v2_next = 1'b1;
        else if (take)
            v2_next = 1'b0;
        else
            v2_next = v2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            c1_reg <= cluster;
        if (adv1)
        begin
            item_reg <= item_next;
            prod_reg <= prod_next;
        end
    end

    assign item_valid = v2_reg;
    assign item       = item_reg;
    assign prod       = prod_reg;

endmodule
`default_nettype wire

// File: design/fccsg_emit.sv
`default_nettype none
module fccsg_emit #(
    parameter int unsigned MAX_CS = fccsg_pkg::MAX_CLUSTER_SECTORS,
    localparam int unsigned CS_W = $clog2(MAX_CS + 1),
    localparam int unsigned PW = fccsg_pkg::CLUSTER_W + CS_W
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    input  wire fccsg_pkg::item_t                 item,
    input  wire logic [PW-1:0]                    prod,
    input  wire fccsg_pkg::geom_t                 geom,
    input  wire logic [CS_W-1:0]                  cs_eff,
    output logic                                  free,
    output logic                                  strobe,
    output fccsg_pkg::kind_t                      kind,
    output logic      [fccsg_pkg::VOL_W-1:0]      sector,
    output logic      [fccsg_pkg::FAT_SEC_W-1:0]  fat_sector,
    output logic      [fccsg_pkg::FAT_WORD_W-1:0] fat_word,
    output fccsg_pkg::err_t                       error_code,
    output logic                                  last
);
    import fccsg_pkg::*;

    localparam int unsigned CMP_W = VOL_W + 1;

    logic                  strobe_reg,   strobe_next;
    logic                  last_reg,     last_next;
    kind_t                 kind_reg,     kind_next;
    err_t                  err_reg,      err_next;
    logic [VOL_W-1:0]      sector_reg,   sector_next;
    logic [FAT_SEC_W-1:0]  fsec_reg,     fsec_next;
    logic [FAT_WORD_W-1:0] fword_reg,    fword_next;
    logic [FAT_SEC_W-1:0]  fsec_hold_reg,  fsec_hold_next;
    logic [FAT_WORD_W-1:0] fword_hold_reg, fword_hold_next;
    logic [CS_W-1:0]       rem_reg,      rem_next;

    logic                  load;
    logic                  in_vol;
    logic [FAT_SEC_W-1:0]  fsec_calc;
    logic [FAT_WORD_W-1:0] fword_calc;

    assign free = !strobe_reg || last_reg;
    assign load = item_valid && free;

    // (c-2)*cs + cs <= volume - first_data  <=>  c < cluster count + 2
    assign in_vol = !geom.short_vol &&
                    ((CMP_W'(prod) + CMP_W'(cs_eff)) <= CMP_W'(geom.avail));

    assign fsec_calc  = FAT_SEC_W'(geom.reserved) + FAT_SEC_W'(item.cluster >> ENTRY_SHIFT);
    assign fword_calc = item.cluster[FAT_WORD_W-1:0];

    always_comb
    begin
        strobe_next     = 1'b0;
        last_next       = last_reg;
        kind_next       = kind_reg;
        err_next        = err_reg;
        sector_next     = sector_reg;
        fsec_next       = fsec_reg;
        fword_next      = fword_reg;
        fsec_hold_next  = fsec_hold_reg;
        fword_hold_next = fword_hold_reg;
        rem_next        = rem_reg;

        if (load)
        begin
            strobe_next     = 1'b1;
            fsec_hold_next  = fsec_calc;
            fword_hold_next = fword_calc;
            sector_next     = '0;
            fsec_next       = '0;
            fword_next      = '0;
            last_next       = 1'b1;
            rem_next        = '0;
            if (item.kind != KIND_DATA)
            begin
                kind_next = item.kind;
                err_next  = item.err;
            end
            else if (!in_vol)
            begin
                kind_next = KIND_ERROR;
                err_next  = ERR_RANGE;
            end
            else
            begin
                kind_next   = KIND_DATA;
                err_next    = ERR_NONE;
                sector_next = VOL_W'(geom.first_data) + VOL_W'(prod);
                last_next   = (cs_eff == CS_W'(1));
                rem_next    = cs_eff - CS_W'(1);
                if (last_next)
                begin
                    fsec_next  = fsec_calc;
                    fword_next = fword_calc;
                end
            end
        end
        else if (strobe_reg && !last_reg)
        begin
            strobe_next = 1'b1;
            sector_next = sector_reg + VOL_W'(1);
            rem_next    = rem_reg - CS_W'(1);
            last_next   = (rem_reg == CS_W'(1));
            fsec_next   = last_next ? fsec_hold_reg : '0;
            fword_next  = last_next ? fword_hold_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        err_reg        <= err_next;
        sector_reg     <= sector_next;
        fsec_reg       <= fsec_next;
        fword_reg      <= fword_next;
        fsec_hold_reg  <= fsec_hold_next;
        fword_hold_reg <= fword_hold_next;
        rem_reg        <= rem_next;
    end

    assign strobe     = strobe_reg;
    assign kind       = kind_reg;
    assign sector     = sector_reg;
    assign fat_sector = fsec_reg;
    assign fat_word   = fword_reg;
    assign error_code = err_reg;
    assign last       = last_reg;

endmodule
`default_nettype wire

// File: design/fat16_cluster_chain_sector_generator.sv
// channel   | direction | handshake                      | beat
// ----------+-----------+--------------------------------+-------------------------------
// command   | in        | start high while busy low      | cluster
// result    | out       | strobe, one cycle, no stall    | kind sector fat_sector
//           |           |                                | fat_word error_code last
// config    | in/out    | APB, write when psel penable   | pwdata at byte address 4*index
//           |           | pwrite (pready tied high)      |
//
// Commands pass the classify and item registers before reaching the result stage.
// A data command in range yields max(cluster_sectors,1) (capped at MAX_CLUSTER_SECTORS,
// 64 by default) beats, one per cycle; any other command yields a single beat.
// A new command enters every cycle the result stage can keep up. After reset and each
// config write, busy stays high while the volume geometry is recomputed.
`default_nettype none
module fat16_cluster_chain_sector_generator #(
    parameter int unsigned MAX_CLUSTER_SECTORS = fccsg_pkg::MAX_CLUSTER_SECTORS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [fccsg_pkg::CLUSTER_W-1:0]  cluster,
    output logic                                  strobe,
    output logic      [1:0]                       kind,
    output logic      [fccsg_pkg::VOL_W-1:0]      sector,
    output logic      [fccsg_pkg::FAT_SEC_W-1:0]  fat_sector,
    output logic      [fccsg_pkg::FAT_WORD_W-1:0] fat_word,
    output logic      [1:0]                       error_code,
    output logic                                  last,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [fccsg_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [fccsg_pkg::DATA_W-1:0]     pwdata,
    output logic      [fccsg_pkg::DATA_W-1:0]     prdata,
    output logic                                  pready
);
    import fccsg_pkg::*;

    localparam int unsigned CS_W = $clog2(MAX_CLUSTER_SECTORS + 1);
    localparam int unsigned PW   = CLUSTER_W + CS_W;

    geom_t           geom;
    logic [CS_W-1:0] cs_eff;
    logic            settling;
    logic            take;
    logic            item_valid;
    item_t           item;
    logic [PW-1:0]   prod;
    kind_t           kind_e;
    err_t            err_e;

    fccsg_cfg #(
        .MAX_CS (MAX_CLUSTER_SECTORS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .geom     (geom),
        .cs_eff   (cs_eff),
        .settling (settling)
    );

    fccsg_classify #(
        .MAX_CS (MAX_CLUSTER_SECTORS)
    ) u_classify (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cluster    (cluster),
        .settling   (settling),
        .cs_eff     (cs_eff),
        .take       (take),
        .busy       (busy),
        .item_valid (item_valid),
        .item       (item),
        .prod       (prod)
    );

    fccsg_emit #(
        .MAX_CS (MAX_CLUSTER_SECTORS)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .prod       (prod),
        .geom       (geom),
        .cs_eff     (cs_eff),
        .free       (take),
        .strobe     (strobe),
        .kind       (kind_e),
        .sector     (sector),
        .fat_sector (fat_sector),
        .fat_word   (fat_word),
        .error_code (err_e),
        .last       (last)
    );

    assign kind       = kind_e;
    assign error_code = err_e;

endmodule
`default_nettype wire

// File: design/fccsg_chk.sv
`default_nettype none
module fccsg_chk (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             busy,
    input wire logic                             strobe,
    input wire logic [1:0]                       kind,
    input wire logic [fccsg_pkg::VOL_W-1:0]      sector,
    input wire logic [fccsg_pkg::FAT_SEC_W-1:0]  fat_sector,
    input wire logic [fccsg_pkg::FAT_WORD_W-1:0] fat_word,
    input wire logic [1:0]                       error_code,
    input wire logic                             last,
    input wire logic                             psel,
    input wire logic                             penable,
    input wire logic                             pwrite
);
    import fccsg_pkg::*;

    // a data run never breaks before its last beat
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("result run broke before last beat");

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind != KIND_DATA) |-> last && (sector == '0) &&
        (fat_sector == '0) && (fat_word == '0))
        else $error("end or error result malformed");

    a_mid_beat: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> (kind == KIND_DATA) && (error_code == ERR_NONE) &&
        (fat_sector == '0) && (fat_word == '0))
        else $error("mid-run beat carries FAT pointer or error");

    a_sector_step: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> sector == $past(sector) + 32'd1)
        else $error("sector did not advance by one");

    a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite |=> busy)
        else $error("command taken right after config write");

endmodule

bind fat16_cluster_chain_sector_generator fccsg_chk u_chk (.*);
`default_nettype wire
